// ===== rtl/rasg_pkg.sv =====
// shared types and constants for the range argmin segment tree
package rasg_pkg;

    // fixed field widths
    localparam int VALUE_W = 32;
    localparam int POS_W   = 10;
    localparam int COUNT_W = 11;

    // default tree size and register reset
    localparam int DEF_LEAVES = 1024;
    localparam logic [COUNT_W-1:0] LEAF_COUNT_RESET = 11'd1024;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_LEAF_COUNT = 1'b0;

    // item action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // input beat
    typedef struct packed {
        logic                      action;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] new_value;
        logic [POS_W-1:0]          query_left;
        logic [POS_W-1:0]          query_right;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic signed [VALUE_W-1:0] min_value;
        logic [POS_W-1:0]          min_position;
        logic                      status;
    } t_out_beat;

    // one tree node: minimum and the leaf holding it
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          index;
    } t_node;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_READ,
        ST_WR_MERGE,
        ST_Q_STEP,
        ST_Q_MERGE,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/rasg_node_mem.sv =====
// node storage: one write port and one registered read port
module rasg_node_mem #(
    parameter int ADDR_W = 11
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  rasg_pkg::t_node      i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    output rasg_pkg::t_node      o_rd_data
);

    rasg_pkg::t_node r_mem [0:(1 << ADDR_W)-1];
    rasg_pkg::t_node r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/rasg_pick.sv =====
// shared compare unit: lesser of two nodes, lower index on a tie
module rasg_pick (
    input  rasg_pkg::t_node i_a,
    input  rasg_pkg::t_node i_b,
    output rasg_pkg::t_node o_min
);

    always_comb begin
        if (i_a.value < i_b.value) begin
            o_min = i_a;
        end else if (i_a.value > i_b.value) begin
            o_min = i_b;
        end else begin
            o_min.value = i_a.value;
            o_min.index = (i_a.index < i_b.index) ? i_a.index : i_b.index;
        end
    end

endmodule

// ===== rtl/rasg_ctrl.sv =====
// sequencer: leaf update walk and bottom-up range query over the node memory
module rasg_ctrl #(
    parameter int LEAVES = rasg_pkg::DEF_LEAVES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  rasg_pkg::t_in_beat             i_in_beat,
    input  logic [rasg_pkg::COUNT_W-1:0]   i_leaf_count,
    output logic                           o_res_valid,
    input  logic                           i_res_take,
    output rasg_pkg::t_out_beat            o_res_beat
);

    localparam int LOGP   = $clog2(LEAVES);
    localparam int ADDR_W = LOGP + 1;
    localparam int BW     = ADDR_W + 1;
    localparam logic [ADDR_W-1:0] LEAF_BASE   = ADDR_W'(1) << LOGP;
    localparam logic [BW-1:0]     LEAF_BASE_B = BW'(1) << LOGP;
    localparam logic [ADDR_W-1:0] ROOT        = ADDR_W'(1);
    localparam logic [31:0]       LEAVES_W    = 32'(LEAVES);

    rasg_pkg::t_state    r_state, n_state;
    logic [ADDR_W-1:0]   r_node, n_node;
    logic [BW-1:0]       r_lo, n_lo, r_hi, n_hi;
    rasg_pkg::t_node     r_acc, n_acc;
    logic                r_have, n_have;
    rasg_pkg::t_out_beat r_res, n_res;

    logic                mem_wr_en, mem_rd_en;
    logic [ADDR_W-1:0]   mem_wr_addr, mem_rd_addr;
    rasg_pkg::t_node     mem_wr_data, mem_rd_data, pick_min, leaf_node;
    logic                accept, wr_bad, q_bad;

    rasg_node_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    rasg_pick u_pick (
        .i_a   (r_acc),
        .i_b   (mem_rd_data),
        .o_min (pick_min)
    );

    // item checks against leaves in use
    assign accept = i_in_valid && o_in_ready;
    assign wr_bad = ({1'b0, i_in_beat.position} >= i_leaf_count)
                 || (32'(i_in_beat.position) >= LEAVES_W);
    assign q_bad  = (i_in_beat.query_left > i_in_beat.query_right)
                 || ({1'b0, i_in_beat.query_right} >= i_leaf_count)
                 || (32'(i_in_beat.query_right) >= LEAVES_W);

    assign leaf_node.value = i_in_beat.new_value;
    assign leaf_node.index = i_in_beat.position;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rasg_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_in_beat.action == rasg_pkg::ACT_WRITE) begin
                        n_state = wr_bad ? rasg_pkg::ST_DONE : rasg_pkg::ST_WR_READ;
                    end else begin
                        n_state = q_bad ? rasg_pkg::ST_DONE : rasg_pkg::ST_Q_STEP;
                    end
                end
            end
            rasg_pkg::ST_WR_READ: begin
                n_state = (r_node == ROOT) ? rasg_pkg::ST_DONE : rasg_pkg::ST_WR_MERGE;
            end
            rasg_pkg::ST_WR_MERGE: begin
                n_state = rasg_pkg::ST_WR_READ;
            end
            rasg_pkg::ST_Q_STEP: begin
                if (r_lo >= r_hi) begin
                    n_state = rasg_pkg::ST_DONE;
                end else if (r_lo[0] || r_hi[0]) begin
                    n_state = rasg_pkg::ST_Q_MERGE;
                end
            end
            rasg_pkg::ST_Q_MERGE: begin
                n_state = rasg_pkg::ST_Q_STEP;
            end
            rasg_pkg::ST_DONE: begin
                if (i_res_take) begin
                    n_state = rasg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rasg_pkg::ST_IDLE;
            end
        endcase
    end

    // handshake and memory port controls
    always_comb begin
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = LEAF_BASE + ADDR_W'(i_in_beat.position);
        mem_wr_data = leaf_node;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_node ^ ROOT;
        case (r_state)
            rasg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                mem_wr_en  = accept && (i_in_beat.action == rasg_pkg::ACT_WRITE) && !wr_bad;
            end
            rasg_pkg::ST_WR_READ: begin
                mem_rd_en = (r_node != ROOT);
            end
            rasg_pkg::ST_WR_MERGE: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_node >> 1;
                mem_wr_data = pick_min;
            end
            rasg_pkg::ST_Q_STEP: begin
                if (r_lo < r_hi) begin
                    if (r_lo[0]) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = ADDR_W'(r_lo);
                    end else if (r_hi[0]) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = ADDR_W'(r_hi - BW'(1));
                    end
                end
            end
            rasg_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_node = r_node;
        n_lo   = r_lo;
        n_hi   = r_hi;
        n_acc  = r_acc;
        n_have = r_have;
        n_res  = r_res;
        case (r_state)
            rasg_pkg::ST_IDLE: begin
                n_res.min_value    = '0;
                n_res.min_position = '0;
                n_res.status       = rasg_pkg::STATUS_OK;
                if (i_in_beat.action == rasg_pkg::ACT_WRITE) begin
                    n_res.status = wr_bad ? rasg_pkg::STATUS_BAD : rasg_pkg::STATUS_OK;
                end else begin
                    n_res.status = q_bad ? rasg_pkg::STATUS_BAD : rasg_pkg::STATUS_OK;
                end
                n_node = LEAF_BASE + ADDR_W'(i_in_beat.position);
                n_acc  = leaf_node;
                n_lo   = LEAF_BASE_B + BW'(i_in_beat.query_left);
                n_hi   = LEAF_BASE_B + BW'(i_in_beat.query_right) + BW'(1);
                n_have = 1'b0;
            end
            rasg_pkg::ST_WR_MERGE: begin
                n_acc  = pick_min;
                n_node = r_node >> 1;
            end
            rasg_pkg::ST_Q_STEP: begin
                if (r_lo >= r_hi) begin
                    n_res.min_value    = r_acc.value;
                    n_res.min_position = r_acc.index;
                    n_res.status       = rasg_pkg::STATUS_OK;
                end else if (r_lo[0]) begin
                    n_lo = r_lo + BW'(1);
                end else if (r_hi[0]) begin
                    n_hi = r_hi - BW'(1);
                end else begin
                    n_lo = r_lo >> 1;
                    n_hi = r_hi >> 1;
                end
            end
            rasg_pkg::ST_Q_MERGE: begin
                n_acc  = r_have ? pick_min : mem_rd_data;
                n_have = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rasg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_node <= n_node;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_acc  <= n_acc;
        r_have <= n_have;
        r_res  <= n_res;
    end

    assign o_res_beat = r_res;

    // the root never has a sibling to fetch
    a_no_root_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_rd_en |-> (mem_rd_addr != '0))
        else $error("node read at unused address zero");

    // a merge always follows a read issued in the cycle before
    a_merge_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rasg_pkg::ST_WR_MERGE || r_state == rasg_pkg::ST_Q_MERGE)
        |-> $past(mem_rd_en))
        else $error("merge without a pending node read");

    // query bounds never cross
    a_bounds_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rasg_pkg::ST_Q_STEP) |-> (r_lo <= r_hi))
        else $error("query bounds crossed");

    // a query result carries at least one merged node
    a_query_has_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rasg_pkg::ST_Q_STEP && r_lo >= r_hi) |-> r_have)
        else $error("query finished with no node merged");

    // a taken result frees the block for the next beat
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_take) |=> o_in_ready)
        else $error("sequencer did not return to idle");

endmodule

// ===== rtl/range_argmin_segment_tree.sv =====
// top level: register port, sequencer and result register of the segment tree
//
// Range minimum with argmin over up to LEAVES signed 32-bit leaves.
// Input channel (i_in_valid / o_in_ready / i_in_beat): a write beat stores
// new_value at position and refreshes its ancestors; a query beat returns the
// minimum over [query_left, query_right] and the lowest leaf holding it.
// Every input beat gives exactly one result beat on the output channel
// (o_out_valid / i_out_ready / o_out_beat). Out-of-use positions and bad
// ranges return status 1 with zero value and position and leave the tree as is.
// A write walks from the leaf to the root, reading each sibling and writing
// the parent; a query climbs from both bounds, reading and merging the
// boundary nodes. Then the result moves into the output register; the
// sequencer takes no new beat before that. The result is offered as soon
// as it is in the output register, and the next beat is accepted in that
// same cycle, even while the result still waits there; a stalled receiver
// only blocks the block once a second result is ready. leaf_count is written
// over the APB port at address 0.
// Reset clears the control state and sets leaf_count to 1024; the node memory
// is not cleared, so every leaf in use must be written before it is queried.
module range_argmin_segment_tree #(
    parameter int LEAVES = rasg_pkg::DEF_LEAVES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rasg_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rasg_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rasg_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  rasg_pkg::t_in_beat                i_in_beat,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output rasg_pkg::t_out_beat               o_out_beat
);

    logic [rasg_pkg::COUNT_W-1:0] r_leaf_count;
    logic                         r_out_valid;
    rasg_pkg::t_out_beat          r_out_beat;
    logic                         res_valid, res_take, reg_sel;
    rasg_pkg::t_out_beat          res_beat;

    // register decode on the word address
    assign reg_sel = (paddr[2] == rasg_pkg::REG_LEAF_COUNT);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? rasg_pkg::APB_DATA_W'(r_leaf_count) : '0;

    // leaf count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_count <= rasg_pkg::LEAF_COUNT_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_leaf_count <= pwdata[rasg_pkg::COUNT_W-1:0];
        end
    end

    rasg_ctrl #(
        .LEAVES (LEAVES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_beat    (i_in_beat),
        .i_leaf_count (r_leaf_count),
        .o_res_valid  (res_valid),
        .i_res_take   (res_take),
        .o_res_beat   (res_beat)
    );

    // output register takes a result when empty or being drained
    assign res_take = res_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_take) begin
            r_out_beat <= res_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// ===== test/rasg_checker.sv =====
// argmin checker: watches the register port and both beat channels, predicts and compares
module rasg_checker
    import rasg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_beat              i_in_beat,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_beat             i_out_beat,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_writes,
    output int                    o_queries,
    output int                    o_flagged
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [APB_ADDR_W-1:0] LEAF_COUNT_ADDR = APB_ADDR_W'(4 * REG_LEAF_COUNT);

    // shadow of the leaf_count register and of every leaf value
    logic [COUNT_W-1:0]        leaf_count_q = LEAF_COUNT_RESET;
    logic signed [VALUE_W-1:0] leaf_val [DEF_LEAVES];

    // results still owed by the block, oldest first
    t_out_beat pending_minima [$];
    t_out_beat want_beat;
    t_out_beat got_beat;
    int errors   = 0;
    int writes   = 0;
    int queries  = 0;
    int flagged  = 0;

    // apply one input beat to the shadow tree and return the result it owes
    function automatic t_out_beat predict_argmin(t_in_beat b);
        t_out_beat r;
        int lim;
        int best;
        r = '0;
        r.status = STATUS_OK;
        lim = (leaf_count_q > DEF_LEAVES) ? DEF_LEAVES : int'(leaf_count_q);
        if (b.action == ACT_WRITE) begin
            if (b.position >= lim) begin
                r.status = STATUS_BAD;
            end else begin
                leaf_val[b.position] = b.new_value;
            end
        end else if (b.query_left > b.query_right || b.query_right >= lim) begin
            r.status = STATUS_BAD;
        end else begin
            // linear scan, strict less keeps the lowest index on ties
            best = b.query_left;
            for (int p = b.query_left + 1; p <= b.query_right; p++) begin
                if (leaf_val[p] < leaf_val[best]) best = p;
            end
            r.min_value    = leaf_val[best];
            r.min_position = POS_W'(best);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            leaf_count_q = LEAF_COUNT_RESET;
            pending_minima.delete();
        end else begin
            // register port: track writes, check reads
            if (psel && penable && pready && paddr == LEAF_COUNT_ADDR) begin
                if (pwrite) begin
                    leaf_count_q = pwdata[COUNT_W-1:0];
                end else if (prdata !== APB_DATA_W'(leaf_count_q)) begin
                    $display("%0t: leaf_count read expected %0d got %0d",
                             $time, leaf_count_q, prdata);
                    errors++;
                end
            end

            // result beat against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                got_beat = i_out_beat;
                if (pending_minima.size() == 0) begin
                    $display("%0t: unexpected result beat value %0d position %0d status %0d",
                             $time, got_beat.min_value, got_beat.min_position,
                             got_beat.status);
                    errors++;
                end else begin
                    want_beat = pending_minima.pop_front();
                    if (got_beat.min_value !== want_beat.min_value) begin
                        $display("%0t: min_value expected %0d got %0d",
                                 $time, want_beat.min_value, got_beat.min_value);
                        errors++;
                    end
                    if (got_beat.min_position !== want_beat.min_position) begin
                        $display("%0t: min_position expected %0d got %0d",
                                 $time, want_beat.min_position, got_beat.min_position);
                        errors++;
                    end
                    if (got_beat.status !== want_beat.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want_beat.status, got_beat.status);
                        errors++;
                    end
                end
            end

            // input beat: predict and queue
            if (i_in_valid && i_in_ready) begin
                want_beat = predict_argmin(i_in_beat);
                pending_minima.insert(pending_minima.size(), want_beat);
                if (i_in_beat.action == ACT_WRITE) writes++;
                else queries++;
                if (want_beat.status == STATUS_BAD) flagged++;
            end
        end
        o_errors  <= errors;
        o_pending <= pending_minima.size();
        o_writes  <= writes;
        o_queries <= queries;
        o_flagged <= flagged;
    end

endmodule

// ===== test/tb.sv =====
// testbench top: clock, reset, register setup, beat stimulus, stalls and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rasg_pkg::*;

    localparam logic [APB_ADDR_W-1:0] LEAF_COUNT_ADDR = APB_ADDR_W'(4 * REG_LEAF_COUNT);
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_beat              i_in_beat  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_beat             o_out_beat;

    int errors;
    int pending;
    int writes_seen;
    int queries_seen;
    int flagged_seen;

    // stimulus-side view of the tree
    int lim_now       = DEF_LEAVES;
    bit leaf_written [DEF_LEAVES];
    int last_pos      = 0;
    int settings_seen = 1;
    bit tx_gaps_on    = 1'b1;
    bit hold_req      = 1'b0;
    int idle_cycles   = 0;

    range_argmin_segment_tree dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    rasg_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_beat  (o_out_beat),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_writes    (writes_seen),
        .o_queries   (queries_seen),
        .o_flagged   (flagged_seen)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog on cycles with no beat and no register access
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result receiver: random stalls, calm stretches and one long hold-off
    initial begin
        int gap;
        int results_taken;
        results_taken = 0;
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            gap = (((results_taken / 50) % 2) == 0) ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            results_taken++;
        end
    end

    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3:    return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    // offer one input beat, holding it until accepted
    task automatic push_beat(t_in_beat b);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_write(int pos, logic signed [VALUE_W-1:0] v);
        t_in_beat b;
        b.action      = ACT_WRITE;
        b.position    = POS_W'(pos);
        b.new_value   = v;
        b.query_left  = POS_W'($urandom);
        b.query_right = POS_W'($urandom);
        if (pos < lim_now) leaf_written[pos] = 1'b1;
        push_beat(b);
    endtask

    task automatic send_query(int lft, int rgt);
        t_in_beat b;
        b.action      = ACT_QUERY;
        b.position    = POS_W'($urandom);
        b.new_value   = $urandom;
        b.query_left  = POS_W'(lft);
        b.query_right = POS_W'(rgt);
        push_beat(b);
    endtask

    // drop valid and wait until every owed result has come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic apb_access(bit wr, logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= LEAF_COUNT_ADDR;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // reprogram leaf_count with the block idle, then read it back
    task automatic set_leaf_count(int n);
        wait_drained();
        apb_access(1'b1, APB_DATA_W'(n));
        apb_access(1'b0, '0);
        lim_now = (n > DEF_LEAVES) ? DEF_LEAVES : n;
        settings_seen++;
    endtask

    // one random phase at a given leaf_count
    task automatic run_phase(int setting, int n_items, bit gaps, bit hold, bit pause);
        int r;
        int p;
        int q;
        int lo;
        int hi;
        int lft;
        set_leaf_count(setting);
        tx_gaps_on = gaps && !hold;
        // small trees are filled first so queries can span them
        if (lim_now <= 128) begin
            for (int k = 0; k < lim_now; k++) begin
                if (!leaf_written[k]) send_write(k, rand_value());
            end
        end
        if (hold) hold_req = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            if (pause && i == n_items / 2) wait_drained();
            r = $urandom_range(0, 99);
            // anchor for a query: some written leaf in use
            p = -1;
            for (int t = 0; t < 8 && p < 0 && lim_now > 0; t++) begin
                q = $urandom_range(0, lim_now - 1);
                if (leaf_written[q]) p = q;
            end
            if (r >= 45 && r < 90 && p >= 0) begin
                // valid query inside the written run around the anchor
                lo = p;
                while (lo > 0 && leaf_written[lo-1]) lo--;
                hi = p;
                while (hi < lim_now - 1 && leaf_written[hi+1]) hi++;
                send_query($urandom_range(lo, p), $urandom_range(p, hi));
            end else if (r >= 90) begin
                // bad range: reversed, or right end past the leaves in use
                if (r >= 95 && lim_now < DEF_LEAVES) begin
                    q = $urandom_range(lim_now, DEF_LEAVES - 1);
                    send_query($urandom_range(0, q), q);
                end else begin
                    lft = $urandom_range(1, DEF_LEAVES - 1);
                    send_query(lft, $urandom_range(0, lft - 1));
                end
            end else if (r >= 40 && r < 45 && lim_now < DEF_LEAVES) begin
                send_write($urandom_range(lim_now, DEF_LEAVES - 1), rand_value());
            end else begin
                // in-range write, often next to the last one to grow runs
                if ($urandom_range(0, 1) == 1 && last_pos + 1 < lim_now) p = last_pos + 1;
                else p = $urandom_range(0, lim_now - 1);
                last_pos = p;
                send_write(p, rand_value());
            end
        end
    endtask

    // main stimulus
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        apb_access(1'b0, '0);

        // extremes, ties and bad ranges at the reset leaf_count
        send_write(0, VAL_MIN);
        send_write(1, VAL_MAX);
        send_write(2, 0);
        send_write(3, VAL_MIN);
        send_write(4, VAL_MAX);
        send_write(DEF_LEAVES - 1, -1);
        send_write(DEF_LEAVES - 2, 5);
        send_query(0, 0);
        send_query(0, 3);
        send_query(1, 3);
        send_query(1, 2);
        send_query(1, 1);
        send_query(0, 4);
        send_query(DEF_LEAVES - 2, DEF_LEAVES - 1);
        send_query(DEF_LEAVES - 1, DEF_LEAVES - 1);
        send_query(3, 2);
        send_query(DEF_LEAVES - 1, 0);

        // no leaf in use: everything flagged
        set_leaf_count(0);
        send_write(0, 7);
        send_query(0, 0);

        // single leaf
        set_leaf_count(1);
        send_write(0, 9);
        send_write(1, 11);
        send_query(0, 0);
        send_query(0, 1);

        // register above the tree size acts as the full tree
        set_leaf_count(2047);
        send_query(DEF_LEAVES - 2, DEF_LEAVES - 1);
        send_write(DEF_LEAVES - 1, VAL_MIN);
        send_query(0, 4);

        // random phases
        run_phase(8, 70, 1'b1, 1'b0, 1'b0);
        run_phase(1024, 70, 1'b0, 1'b1, 1'b0);
        run_phase(2, 60, 1'b1, 1'b0, 1'b1);
        run_phase(100, 70, 1'b0, 1'b0, 1'b0);
        run_phase(1500, 70, 1'b1, 1'b0, 1'b0);
        run_phase($urandom_range(1, 1024), 70, 1'b1, 1'b0, 1'b1);
        run_phase(33, 70, 1'b1, 1'b0, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d writes and %0d queries, %0d of them flagged,",
                 writes_seen, queries_seen, flagged_seen);
        $display("across %0d leaf_count settings with stalls on both channels", settings_seen);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rasg_pkg.sv
rtl/rasg_node_mem.sv
rtl/rasg_pick.sv
rtl/rasg_ctrl.sv
rtl/range_argmin_segment_tree.sv
test/rasg_checker.sv
test/tb.sv
